### rtl/core/tcpsm_pkg.sv
// Shared types and constants of the TCP connection engine.
`timescale 1ns / 1ps
package tcpsm_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_RESULTS = 4;
   localparam int RIDX_W      = $clog2(MAX_RESULTS);
   localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
   localparam int PADDR_W     = 4;

   localparam logic [15:0] LISTEN_PORT_RST = 16'd7;
   localparam logic [15:0] RECV_WIN_RST    = 16'(8 * 1024);
   localparam logic [15:0] MSS_RST         = 16'd1460;

   localparam logic [PADDR_W-3:0] REG_LISTEN_PORT = 2'd0;
   localparam logic [PADDR_W-3:0] REG_RECV_WIN    = 2'd1;
   localparam logic [PADDR_W-3:0] REG_MSS         = 2'd2;

   localparam logic [7:0] FLG_FIN    = 8'h01;
   localparam logic [7:0] FLG_SYN    = 8'h02;
   localparam logic [7:0] FLG_RST    = 8'h04;
   localparam logic [7:0] FLG_ACK    = 8'h10;
   localparam logic [7:0] FLG_FINACK = 8'h11;
   localparam logic [7:0] FLG_SYNACK = 8'h12;
   localparam logic [7:0] FLG_PSHACK = 8'h18;

   typedef enum logic [1:0] {
      OP_SEGMENT, OP_SEND, OP_CLOSE, OP_UNUSED
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_FLAGS, KIND_DATA, KIND_DELIVER, KIND_EOF,
      KIND_ALLSENT, KIND_ESTAB, KIND_DELETED, KIND_DROPPED
   } kind_type;

   typedef struct packed {
      opcode_type  cmd;
      logic [31:0] peer_address;
      logic [15:0] peer_port;
      logic [15:0] local_port;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [15:0] window;
      logic [15:0] len;
      logic [31:0] iss;
      logic        syn;
      logic        rst;
      logic        psh_ack;
      logic        fin_ack;
      logic        ack_only;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_head_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
   } q_stat_type;

   typedef struct packed {
      logic [15:0] listen_port;
      logic [15:0] receive_window;
      logic [15:0] max_segment_size;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  seg_flags;
      logic [31:0] seq_out;
      logic [31:0] ack_out;
      logic [15:0] window_out;
      logic [15:0] src_port_out;
      logic [15:0] dst_port_out;
      logic [31:0] dst_address_out;
      logic [15:0] data_offset;
      logic [15:0] data_len;
      logic        last;
   } rsp_type;

endpackage

### rtl/core/tcpsm_req_if.sv
// Request channel interface.
`timescale 1ns / 1ps
interface tcpsm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] peer_address_in;
   logic [15:0] peer_port_in;
   logic [15:0] local_port_in;
   logic [31:0] seq_in;
   logic [31:0] ack_in;
   logic [7:0]  flags_in;
   logic [15:0] window_in;
   logic [15:0] payload_len;
   logic [31:0] initial_seq;

   modport source (output valid, opcode, peer_address_in, peer_port_in, local_port_in,
                   seq_in, ack_in, flags_in, window_in, payload_len, initial_seq,
                   input ready);
   modport sink (input valid, opcode, peer_address_in, peer_port_in, local_port_in,
                 seq_in, ack_in, flags_in, window_in, payload_len, initial_seq,
                 output ready);
endinterface

### rtl/core/tcpsm_rsp_if.sv
// Result channel interface.
`timescale 1ns / 1ps
interface tcpsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  seg_flags;
   logic [31:0] seq_out;
   logic [31:0] ack_out;
   logic [15:0] window_out;
   logic [15:0] src_port_out;
   logic [15:0] dst_port_out;
   logic [31:0] dst_address_out;
   logic [15:0] data_offset;
   logic [15:0] data_len;
   logic        last;

   modport source (output valid, kind, seg_flags, seq_out, ack_out, window_out,
                   src_port_out, dst_port_out, dst_address_out, data_offset,
                   data_len, last, input ready);
   modport sink (input valid, kind, seg_flags, seq_out, ack_out, window_out,
                 src_port_out, dst_port_out, dst_address_out, data_offset,
                 data_len, last, output ready);
endinterface

### rtl/core/tcp_connection_state_machine.sv
// Top level of the single-slot server-side TCP connection engine.
`timescale 1ns / 1ps
// Usage:
//  - req_chan carries one event per request: an arrived segment header,
//    an application send or an application close. Accepted on valid&ready.
//  - rsp_chan returns zero to four results per request, in order; the final
//    result of a request has last set. A request with no result emits nothing.
//  - csr_* is an APB-style port: listen_port at 0x0, receive_window at 0x4,
//    max_segment_size at 0x8. pready is tied high. Write only while idle.
// Timing:
//  - A request is registered in the two-entry front queue, then the back
//    end updates the connection and loads its results.
//  - Results leave one per cycle while rsp_chan is ready; the result
//    buffer drain sets the throughput.
//  - The first result is offered once the request has passed the front
//    queue and has been loaded into the result buffer.
// Reset (synchronous, active high) frees the slot, empties queue and result
// buffer, and restores register defaults (port 7, window 8192, MSS 1460).
// A stalled rsp_chan holds the current result; the queue keeps taking
// requests until both entries are full, then req_chan.ready drops.
module tcp_connection_state_machine (
   input  logic                          clock,
   input  logic                          reset,
   tcpsm_req_if.sink                     req_chan,
   tcpsm_rsp_if.source                   rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tcpsm_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   tcpsm_pkg::cfg_type    cfg_ff;
   tcpsm_pkg::q_head_type head;
   tcpsm_pkg::q_stat_type stat;
   logic                  pop;
   logic                  csr_wr;
   logic [tcpsm_pkg::PADDR_W-3:0] reg_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[tcpsm_pkg::PADDR_W-1:2];

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.listen_port      <= tcpsm_pkg::LISTEN_PORT_RST;
         cfg_ff.receive_window   <= tcpsm_pkg::RECV_WIN_RST;
         cfg_ff.max_segment_size <= tcpsm_pkg::MSS_RST;
      end else if (csr_wr) begin
         case (reg_idx)
            tcpsm_pkg::REG_LISTEN_PORT: cfg_ff.listen_port      <= csr_pwdata[15:0];
            tcpsm_pkg::REG_RECV_WIN:    cfg_ff.receive_window   <= csr_pwdata[15:0];
            tcpsm_pkg::REG_MSS:         cfg_ff.max_segment_size <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         tcpsm_pkg::REG_LISTEN_PORT: csr_prdata = {16'd0, cfg_ff.listen_port};
         tcpsm_pkg::REG_RECV_WIN:    csr_prdata = {16'd0, cfg_ff.receive_window};
         tcpsm_pkg::REG_MSS:         csr_prdata = {16'd0, cfg_ff.max_segment_size};
         default:                    csr_prdata = '0;
      endcase
   end

   // front: accept and decode, two-entry queue
   tcpsm_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .pop   (pop),
      .head  (head),
      .stat  (stat)
   );

   // back: connection update and result buffer
   tcpsm_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= tcpsm_pkg::QCNT_W'(tcpsm_pkg::QUEUE_DEPTH))
      else $error("front queue over capacity");

   // an accepted request is in the queue the cycle after
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (stat.count != '0))
      else $error("accepted request missing from queue");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result offered after reset");

   // back end only takes a request that the queue holds
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> (stat.count != '0))
      else $error("pop from empty queue");
endmodule

### rtl/core/tcpsm_front.sv
// Front end: accepts requests, decodes opcode and flags, queues them.
`timescale 1ns / 1ps
module tcpsm_front (
   input  logic                 clock,
   input  logic                 reset,
   tcpsm_req_if.sink            req,
   input  logic                 pop,
   output tcpsm_pkg::q_head_type head,
   output tcpsm_pkg::q_stat_type stat
);
   tcpsm_pkg::entry_type entry_ff [tcpsm_pkg::QUEUE_DEPTH];
   logic [tcpsm_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [tcpsm_pkg::QCNT_W-1:0] count_ff, count_in;
   tcpsm_pkg::entry_type         dec;
   logic                         push;

   always_comb begin
      dec.cmd          = tcpsm_pkg::opcode_type'(req.opcode);
      dec.peer_address = req.peer_address_in;
      dec.peer_port    = req.peer_port_in;
      dec.local_port   = req.local_port_in;
      dec.seq          = req.seq_in;
      dec.ack          = req.ack_in;
      dec.window       = req.window_in;
      dec.len          = req.payload_len;
      dec.iss          = req.initial_seq;
      dec.syn          = |(req.flags_in & tcpsm_pkg::FLG_SYN);
      dec.rst          = |(req.flags_in & tcpsm_pkg::FLG_RST);
      dec.psh_ack      = (req.flags_in & tcpsm_pkg::FLG_PSHACK) == tcpsm_pkg::FLG_PSHACK;
      dec.fin_ack      = !dec.psh_ack &&
                         ((req.flags_in & tcpsm_pkg::FLG_FINACK) == tcpsm_pkg::FLG_FINACK);
      dec.ack_only     = !dec.psh_ack && !dec.fin_ack && |(req.flags_in & tcpsm_pkg::FLG_ACK);
   end

   assign req.ready  = count_ff != tcpsm_pkg::QCNT_W'(tcpsm_pkg::QUEUE_DEPTH);
   assign push       = req.valid && req.ready;
   assign head.valid = count_ff != '0;
   assign head.entry = entry_ff[rd_ptr_ff];
   assign stat.count = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !(pop && head.valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop && head.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop && head.valid) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

### rtl/core/tcpsm_back.sv
// Back end: connection state update and result buffer.
`timescale 1ns / 1ps
module tcpsm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tcpsm_pkg::cfg_type    cfg,
   input  tcpsm_pkg::q_head_type head,
   output logic                  pop,
   tcpsm_rsp_if.source           rsp
);
   typedef enum logic [2:0] {
      ST_LISTEN, ST_SYNRCVD, ST_ESTAB, ST_FINW1, ST_FINW2
   } conn_state_type;

   typedef struct packed {
      logic           busy;
      conn_state_type state;
      logic [31:0]    peer_address;
      logic [15:0]    peer_port;
      logic [15:0]    local_port;
      logic [31:0]    recv_next;
      logic [31:0]    send_next;
      logic [31:0]    send_unacked;
      logic [31:0]    first_seq;
      logic [15:0]    queue_length;
      logic [15:0]    peer_window;
   } conn_type;

   conn_type conn_ff, conn_in;
   tcpsm_pkg::rsp_type res_ff [tcpsm_pkg::MAX_RESULTS];
   tcpsm_pkg::rsp_type res_in [tcpsm_pkg::MAX_RESULTS];
   logic [tcpsm_pkg::RCNT_W-1:0] res_cnt_ff, n;
   logic [tcpsm_pkg::RIDX_W-1:0] res_idx_ff;
   logic                         drain_done;

   function automatic tcpsm_pkg::rsp_type mk_seg(input tcpsm_pkg::kind_type kind,
                                                 input logic [7:0] flags,
                                                 input conn_type c,
                                                 input logic [15:0] win,
                                                 input logic [15:0] off,
                                                 input logic [15:0] len);
      tcpsm_pkg::rsp_type r;
      r.kind            = kind;
      r.seg_flags       = flags;
      r.seq_out         = c.send_next;
      r.ack_out         = c.recv_next;
      r.window_out      = win;
      r.src_port_out    = c.local_port;
      r.dst_port_out    = c.peer_port;
      r.dst_address_out = c.peer_address;
      r.data_offset     = off;
      r.data_len        = len;
      r.last            = 1'b0;
      return r;
   endfunction

   function automatic tcpsm_pkg::rsp_type mk_evt(input tcpsm_pkg::kind_type kind,
                                                 input logic [15:0] len);
      tcpsm_pkg::rsp_type r;
      r          = '0;
      r.kind     = kind;
      r.data_len = len;
      return r;
   endfunction

   // Output side: a result leaves per cycle while rsp.ready is high; the next
   // request is taken as the last buffered result is handed off.
   assign rsp.valid = res_cnt_ff != '0;
   assign drain_done = (res_cnt_ff == '0) ||
                       (rsp.ready && ({1'b0, res_idx_ff} + 1'b1) == res_cnt_ff);
   assign pop = head.valid && drain_done;

   assign rsp.kind            = res_ff[res_idx_ff].kind;
   assign rsp.seg_flags       = res_ff[res_idx_ff].seg_flags;
   assign rsp.seq_out         = res_ff[res_idx_ff].seq_out;
   assign rsp.ack_out         = res_ff[res_idx_ff].ack_out;
   assign rsp.window_out      = res_ff[res_idx_ff].window_out;
   assign rsp.src_port_out    = res_ff[res_idx_ff].src_port_out;
   assign rsp.dst_port_out    = res_ff[res_idx_ff].dst_port_out;
   assign rsp.dst_address_out = res_ff[res_idx_ff].dst_address_out;
   assign rsp.data_offset     = res_ff[res_idx_ff].data_offset;
   assign rsp.data_len        = res_ff[res_idx_ff].data_len;
   assign rsp.last            = res_ff[res_idx_ff].last;

   always_comb begin
      tcpsm_pkg::entry_type e;
      logic        do_ack, sfq;
      logic [31:0] inflight, off;
      logic [15:0] win, left, slen;
      e        = head.entry;
      conn_in  = conn_ff;
      n        = '0;
      do_ack   = 1'b0;
      sfq      = 1'b0;
      inflight = '0;
      off      = '0;
      win      = '0;
      left     = '0;
      slen     = '0;
      for (int i = 0; i < tcpsm_pkg::MAX_RESULTS; i++) begin
         res_in[i] = '0;
      end
      case (e.cmd)
         tcpsm_pkg::OP_SEGMENT: begin
            if (conn_ff.busy) begin
               if (e.peer_address != conn_ff.peer_address || e.peer_port != conn_ff.peer_port ||
                   e.local_port != conn_ff.local_port) begin
                  res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_evt(tcpsm_pkg::KIND_DROPPED, '0);
                  n = n + 1'b1;
               end else begin
                  conn_in.peer_window = e.window;
                  if (e.psh_ack) begin
                     if (conn_in.state == ST_ESTAB && e.seq == conn_in.recv_next) begin
                        conn_in.recv_next    = conn_in.recv_next + {16'd0, e.len};
                        conn_in.send_unacked = conn_in.send_next;
                        res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_seg(tcpsm_pkg::KIND_FLAGS,
                           tcpsm_pkg::FLG_ACK, conn_in, cfg.receive_window, '0, '0);
                        n = n + 1'b1;
                        res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_evt(tcpsm_pkg::KIND_DELIVER, e.len);
                        n = n + 1'b1;
                     end
                  end
                  do_ack = e.fin_ack || e.ack_only;
                  // Acknowledge handling
                  if (do_ack) begin
                     case (conn_in.state)
                        ST_SYNRCVD: begin
                           if (e.ack == conn_in.send_next) begin
                              conn_in.state        = ST_ESTAB;
                              conn_in.first_seq    = conn_in.send_next;
                              conn_in.queue_length = '0;
                              res_in[n[tcpsm_pkg::RIDX_W-1:0]] =
                                 mk_evt(tcpsm_pkg::KIND_ESTAB, '0);
                              n = n + 1'b1;
                           end else begin
                              conn_in.busy  = 1'b0;
                              conn_in.state = ST_LISTEN;
                              res_in[n[tcpsm_pkg::RIDX_W-1:0]] =
                                 mk_evt(tcpsm_pkg::KIND_DELETED, '0);
                              n = n + 1'b1;
                           end
                        end
                        ST_ESTAB: begin
                           inflight = e.ack - conn_in.send_unacked;
                           if (inflight != '0 && !inflight[31]) begin
                              conn_in.send_unacked = e.ack;
                           end
                           if (conn_in.send_next - conn_in.first_seq ==
                               {16'd0, conn_in.queue_length}) begin
                              res_in[n[tcpsm_pkg::RIDX_W-1:0]] =
                                 mk_evt(tcpsm_pkg::KIND_ALLSENT, '0);
                              n = n + 1'b1;
                           end else begin
                              sfq = 1'b1;
                           end
                        end
                        ST_FINW1: begin
                           if (e.ack == conn_in.send_next) begin
                              conn_in.state = ST_FINW2;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end else if (!e.syn) begin
               res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_evt(tcpsm_pkg::KIND_DELETED, '0);
               n = n + 1'b1;
            end else begin
               conn_in.busy         = 1'b1;
               conn_in.state        = ST_LISTEN;
               conn_in.peer_address = e.peer_address;
               conn_in.peer_port    = e.peer_port;
               conn_in.local_port   = e.local_port;
               if (e.local_port == cfg.listen_port) begin
                  conn_in.recv_next    = e.seq + 32'd1;
                  conn_in.send_next    = e.iss;
                  conn_in.send_unacked = e.iss;
                  res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_seg(tcpsm_pkg::KIND_FLAGS,
                     tcpsm_pkg::FLG_SYNACK, conn_in, cfg.receive_window, '0, '0);
                  n = n + 1'b1;
                  conn_in.send_next = e.iss + 32'd1;
                  conn_in.state     = ST_SYNRCVD;
               end else begin
                  conn_in.recv_next = '0;
                  conn_in.send_next = '0;
                  res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_seg(tcpsm_pkg::KIND_FLAGS,
                     tcpsm_pkg::FLG_RST, conn_in, cfg.receive_window, '0, '0);
                  n = n + 1'b1;
                  conn_in.busy  = 1'b0;
                  conn_in.state = ST_LISTEN;
                  res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_evt(tcpsm_pkg::KIND_DELETED, '0);
                  n = n + 1'b1;
               end
            end
         end
         tcpsm_pkg::OP_SEND: begin
            if (conn_ff.busy && conn_ff.state == ST_ESTAB) begin
               conn_in.queue_length = e.len;
               conn_in.first_seq    = conn_ff.send_next;
               sfq                  = 1'b1;
            end
         end
         tcpsm_pkg::OP_CLOSE: begin
            if (conn_ff.busy && conn_ff.state == ST_ESTAB) begin
               conn_in.state = ST_FINW1;
               res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_seg(tcpsm_pkg::KIND_FLAGS,
                  tcpsm_pkg::FLG_FINACK, conn_in, cfg.receive_window, '0, '0);
               n = n + 1'b1;
               conn_in.send_next = conn_ff.send_next + 32'd1;
            end
         end
         default: ;
      endcase

      // Window-limited transmit from the application buffer
      if (sfq) begin
         inflight = conn_in.send_next - conn_in.send_unacked;
         win  = ({16'd0, conn_in.peer_window} > inflight) ?
                conn_in.peer_window - inflight[15:0] : '0;
         off  = conn_in.send_next - conn_in.first_seq;
         left = ({16'd0, conn_in.queue_length} > off) ?
                conn_in.queue_length - off[15:0] : '0;
         slen = (left > cfg.max_segment_size) ? cfg.max_segment_size : left;
         slen = (slen > win) ? win : slen;
         res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_seg(tcpsm_pkg::KIND_DATA,
            tcpsm_pkg::FLG_PSHACK, conn_in, cfg.receive_window, off[15:0], slen);
         n = n + 1'b1;
         conn_in.send_next = conn_in.send_next + {16'd0, slen};
      end

      // FIN handling after the acknowledge
      if (e.cmd == tcpsm_pkg::OP_SEGMENT && conn_ff.busy && e.fin_ack && conn_in.busy &&
          e.peer_address == conn_ff.peer_address && e.peer_port == conn_ff.peer_port &&
          e.local_port == conn_ff.local_port) begin
         if (conn_in.state inside {ST_ESTAB, ST_FINW2}) begin
            conn_in.recv_next = conn_in.recv_next + 32'd1;
            res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_seg(tcpsm_pkg::KIND_FLAGS,
               tcpsm_pkg::FLG_ACK, conn_in, cfg.receive_window, '0, '0);
            n = n + 1'b1;
            if (conn_in.state == ST_ESTAB) begin
               res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_evt(tcpsm_pkg::KIND_EOF, '0);
            end else begin
               conn_in.busy  = 1'b0;
               conn_in.state = ST_LISTEN;
               res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_evt(tcpsm_pkg::KIND_DELETED, '0);
            end
            n = n + 1'b1;
         end
      end

      // Reset flag on a live, matching connection
      if (e.cmd == tcpsm_pkg::OP_SEGMENT && conn_ff.busy && e.rst && conn_in.busy &&
          e.peer_address == conn_ff.peer_address && e.peer_port == conn_ff.peer_port &&
          e.local_port == conn_ff.local_port) begin
         conn_in.busy  = 1'b0;
         conn_in.state = ST_LISTEN;
         res_in[n[tcpsm_pkg::RIDX_W-1:0]] = mk_evt(tcpsm_pkg::KIND_DELETED, '0);
         n = n + 1'b1;
      end

      for (int i = 0; i < tcpsm_pkg::MAX_RESULTS; i++) begin
         res_in[i].last = (tcpsm_pkg::RCNT_W'(i) + 1'b1) == n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_ff    <= '0;
         res_cnt_ff <= '0;
         res_idx_ff <= '0;
      end else if (pop) begin
         conn_ff    <= conn_in;
         res_cnt_ff <= n;
         res_idx_ff <= '0;
      end else if (rsp.valid && rsp.ready) begin
         if (drain_done) begin
            res_cnt_ff <= '0;
            res_idx_ff <= '0;
         end else begin
            res_idx_ff <= res_idx_ff + 1'b1;
         end
      end
      if (pop) begin
         res_ff <= res_in;
      end
   end
endmodule
